@@ rtl/stok_pkg.sv @@
package stok_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LENGTH_BITS   = 12;
    localparam int LINE_BITS     = 16;

    localparam int MAX_RESULTS = 3;
    localparam int SCAN_PASSES = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
    localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int WORD_BYTES  = 5;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_COMMENT = 8'b0000_0010,
        M_INT     = 8'b0000_0100,
        M_DOT     = 8'b0000_1000,
        M_FRAC    = 8'b0001_0000,
        M_STRING  = 8'b0010_0000,
        M_IDENT   = 8'b0100_0000,
        M_OP      = 8'b1000_0000
    } mode_t;

    localparam logic [5:0] KIND_EOF      = 6'd0;
    localparam logic [5:0] KIND_ERROR    = 6'd1;
    localparam logic [5:0] KIND_NEWLINE  = 6'd2;
    localparam logic [5:0] KIND_NUMBER   = 6'd3;
    localparam logic [5:0] KIND_STRING   = 6'd4;
    localparam logic [5:0] KIND_IDENT    = 6'd5;
    localparam logic [5:0] KIND_KW_FIRST = 6'd6;
    localparam logic [5:0] KIND_NE       = 6'd17;
    localparam logic [5:0] KIND_GE       = 6'd18;
    localparam logic [5:0] KIND_POW      = 6'd19;
    localparam logic [5:0] KIND_PIPE_GT  = 6'd20;
    localparam logic [5:0] KIND_ARROW    = 6'd21;
    localparam logic [5:0] KIND_LE       = 6'd22;
    localparam logic [5:0] KIND_LPAREN   = 6'd23;
    localparam logic [5:0] KIND_RPAREN   = 6'd24;
    localparam logic [5:0] KIND_LBRACKET = 6'd25;
    localparam logic [5:0] KIND_RBRACKET = 6'd26;
    localparam logic [5:0] KIND_LBRACE   = 6'd27;
    localparam logic [5:0] KIND_RBRACE   = 6'd28;
    localparam logic [5:0] KIND_COMMA    = 6'd29;
    localparam logic [5:0] KIND_DOT      = 6'd30;
    localparam logic [5:0] KIND_MINUS    = 6'd31;
    localparam logic [5:0] KIND_PLUS     = 6'd32;
    localparam logic [5:0] KIND_STAR     = 6'd33;
    localparam logic [5:0] KIND_SLASH    = 6'd34;
    localparam logic [5:0] KIND_PIPE     = 6'd35;
    localparam logic [5:0] KIND_EQUAL    = 6'd36;
    localparam logic [5:0] KIND_GT       = 6'd37;
    localparam logic [5:0] KIND_LT       = 6'd38;
    localparam logic [5:0] KIND_COLON    = 6'd39;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd1;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = " ";
    localparam logic [7:0] CH_BANG     = "!";
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_LPAREN   = "(";
    localparam logic [7:0] CH_RPAREN   = ")";
    localparam logic [7:0] CH_STAR     = "*";
    localparam logic [7:0] CH_PLUS     = "+";
    localparam logic [7:0] CH_COMMA    = ",";
    localparam logic [7:0] CH_MINUS    = "-";
    localparam logic [7:0] CH_DOT      = ".";
    localparam logic [7:0] CH_SLASH    = "/";
    localparam logic [7:0] CH_ZERO     = "0";
    localparam logic [7:0] CH_NINE     = "9";
    localparam logic [7:0] CH_COLON    = ":";
    localparam logic [7:0] CH_SEMI     = ";";
    localparam logic [7:0] CH_LT       = "<";
    localparam logic [7:0] CH_EQUAL    = "=";
    localparam logic [7:0] CH_GT       = ">";
    localparam logic [7:0] CH_LBRACKET = "[";
    localparam logic [7:0] CH_RBRACKET = "]";
    localparam logic [7:0] CH_UNDER    = "_";
    localparam logic [7:0] CH_LBRACE   = "{";
    localparam logic [7:0] CH_PIPE     = "|";
    localparam logic [7:0] CH_RBRACE   = "}";

    localparam int KW_COUNT = 11;

    localparam logic [8*WORD_BYTES-1:0] KW_WORD [KW_COUNT] = '{
        40'("true"), 40'("false"), 40'("nil"), 40'("and"), 40'("not"), 40'("cond"),
        40'("def"), 40'("do"), 40'("else"), 40'("end"), 40'("or")
    };

    localparam logic [LENGTH_BITS-1:0] KW_LEN [KW_COUNT] = '{
        LENGTH_BITS'(4), LENGTH_BITS'(5), LENGTH_BITS'(3), LENGTH_BITS'(3),
        LENGTH_BITS'(3), LENGTH_BITS'(4), LENGTH_BITS'(3), LENGTH_BITS'(2),
        LENGTH_BITS'(4), LENGTH_BITS'(3), LENGTH_BITS'(2)
    };

    typedef struct packed {
        logic [5:0]               kind;
        logic [1:0]               err;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   len;
        logic [LINE_BITS-1:0]     line;
        logic [LINE_BITS-1:0]     col;
        logic                     last;
    } token_t;

    function automatic token_t make_tok(
        input logic [5:0]               kind,
        input logic [1:0]               err,
        input logic [POSITION_BITS-1:0] start,
        input logic [LENGTH_BITS-1:0]   len,
        input logic [LINE_BITS-1:0]     line,
        input logic [LINE_BITS-1:0]     col
    );
        token_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = start;
        t.len   = len;
        t.line  = line;
        t.col   = col;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_sym(input logic [7:0] b);
        logic r;
        case (b)
            CH_NUL, CH_SPACE, CH_TAB, CH_LF, CH_CR,
            CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
            CH_QUOTE, CH_COLON, CH_SEMI, CH_DOT, CH_COMMA: r = 1'b0;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] b);
        logic [5:0] k;
        case (b)
            CH_LPAREN:   k = KIND_LPAREN;
            CH_RPAREN:   k = KIND_RPAREN;
            CH_LBRACKET: k = KIND_LBRACKET;
            CH_RBRACKET: k = KIND_RBRACKET;
            CH_LBRACE:   k = KIND_LBRACE;
            CH_RBRACE:   k = KIND_RBRACE;
            CH_COMMA:    k = KIND_COMMA;
            CH_DOT:      k = KIND_DOT;
            CH_MINUS:    k = KIND_MINUS;
            CH_PLUS:     k = KIND_PLUS;
            CH_STAR:     k = KIND_STAR;
            CH_SLASH:    k = KIND_SLASH;
            CH_PIPE:     k = KIND_PIPE;
            CH_EQUAL:    k = KIND_EQUAL;
            CH_GT:       k = KIND_GT;
            CH_LT:       k = KIND_LT;
            CH_COLON:    k = KIND_COLON;
            default:     k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic is_op_start(input logic [7:0] b);
        return (b == CH_BANG) || (b == CH_GT) || (b == CH_STAR) || (b == CH_PIPE)
            || (b == CH_MINUS) || (b == CH_LT);
    endfunction

    function automatic logic pair_match(input logic [7:0] a, input logic [7:0] b);
        logic r;
        case (a)
            CH_BANG, CH_GT, CH_LT: r = (b == CH_EQUAL);
            CH_STAR:               r = (b == CH_STAR);
            CH_PIPE, CH_MINUS:     r = (b == CH_GT);
            default:               r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] a);
        logic [5:0] k;
        case (a)
            CH_BANG:  k = KIND_NE;
            CH_GT:    k = KIND_GE;
            CH_STAR:  k = KIND_POW;
            CH_PIPE:  k = KIND_PIPE_GT;
            CH_MINUS: k = KIND_ARROW;
            default:  k = KIND_LE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] kw_kind(
        input logic [8*WORD_BYTES-1:0] word,
        input logic [LENGTH_BITS-1:0]  len
    );
        logic [5:0] k;
        k = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if ((len == KW_LEN[i]) && (word == KW_WORD[i]))
            begin
                k = KIND_KW_FIRST + 6'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [LINE_BITS-1:0] sat_inc_line(input logic [LINE_BITS-1:0] x);
        return (x == LINE_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc_len(input logic [LENGTH_BITS-1:0] x);
        return (x == LEN_MAX) ? x : x + 1'b1;
    endfunction

endpackage

@@ rtl/source_tokenizer.sv @@
// Byte-serial source scanner: one text byte per in_valid/in_ready transfer, one token per
// out_valid/out_ready transfer, byte 0 ends the text and yields EOF (an unterminated error
// inside a string). A byte goes into an input register, is scanned, and its tokens are
// written into a four-entry token queue that drains one token per cycle while out_ready is
// high. The sustained rate is one byte per cycle while each byte yields at most one token
// and the output does not stall; the queue takes a byte only with room for three tokens,
// so a byte that yields two or three tokens holds up the input until there is room. After
// an error token or EOF, bytes are still taken but yield nothing until reset.
module source_tokenizer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         text_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [5:0]                         token_kind,
    output logic [1:0]                         error_code,
    output logic [stok_pkg::POSITION_BITS-1:0] start_offset,
    output logic [stok_pkg::LENGTH_BITS-1:0]   token_length,
    output logic [stok_pkg::LINE_BITS-1:0]     line_number,
    output logic [stok_pkg::LINE_BITS-1:0]     column_number,
    output logic                               last_of_run
);

    import stok_pkg::*;

    logic [7:0]               byte_reg;
    logic                     byte_valid_reg;
    logic                     fire;

    mode_t                    mode_reg, mode_next;
    logic [7:0]               held_reg, held_next;
    logic [8*WORD_BYTES-1:0]  word_reg, word_next;
    logic [LENGTH_BITS-1:0]   run_reg, run_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [LINE_BITS-1:0]     col_reg, col_next;
    logic                     halted_reg, halted_next;

    token_t                   tok_new [MAX_RESULTS];
    logic [RES_BITS-1:0]      tok_count;

    token_t                   queue_reg [QDEPTH];
    logic [QPTR_BITS-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]     count_reg;
    logic                     pop;
    logic [RES_BITS-1:0]      push_n;
    token_t                   head;

    assign fire     = byte_valid_reg && (count_reg <= QCNT_BITS'(QDEPTH - MAX_RESULTS));
    assign in_ready = !byte_valid_reg || fire;
    assign push_n   = fire ? tok_count : '0;

    always_comb
    begin : scan_comb
        mode_t                    m;
        logic [7:0]               b;
        logic [7:0]               hb;
        logic [8*WORD_BYTES-1:0]  wb;
        logic [LENGTH_BITS-1:0]   rl;
        logic [POSITION_BITS-1:0] ts;
        logic [POSITION_BITS-1:0] ps;
        logic [POSITION_BITS-1:0] s;
        logic [LINE_BITS-1:0]     ln;
        logic [LINE_BITS-1:0]     cl;
        logic                     hl;
        logic                     done;
        logic [RES_BITS-1:0]      n;

        b    = byte_reg;
        m    = mode_reg;
        hb   = held_reg;
        wb   = word_reg;
        rl   = run_reg;
        ts   = start_reg;
        ps   = pos_reg;
        ln   = line_reg;
        cl   = col_reg;
        hl   = halted_reg;
        done = halted_reg;
        n    = '0;
        s    = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            tok_new[i] = '0;
        end

        for (int p = 0; p < SCAN_PASSES; p++)
        begin
            if (!done)
            begin
                case (m)
                    M_COMMENT:
                    begin
                        if (b == CH_NUL)
                        begin
                            m = M_IDLE;
                        end
                        else
                        begin
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            if ((b == CH_LF) || (b == CH_CR))
                            begin
                                ln = sat_inc_line(ln);
                                cl = LINE_BITS'(1);
                                m  = M_IDLE;
                            end
                            done = 1'b1;
                        end
                    end
                    M_INT, M_FRAC:
                    begin
                        if (is_digit(b) || (b == CH_UNDER))
                        begin
                            ps   = ps + 1'b1;
                            cl   = sat_inc_line(cl);
                            rl   = sat_inc_len(rl);
                            done = 1'b1;
                        end
                        else if ((b == CH_DOT) && (m == M_INT))
                        begin
                            m    = M_DOT;
                            done = 1'b1;
                        end
                        else
                        begin
                            tok_new[n] = make_tok(KIND_NUMBER, ERR_NONE, ts, rl, ln, cl);
                            n = n + 1'b1;
                            m = M_IDLE;
                        end
                    end
                    M_DOT:
                    begin
                        if (is_digit(b))
                        begin
                            ps   = ps + 2'd2;
                            cl   = sat_inc_line(sat_inc_line(cl));
                            rl   = sat_inc_len(sat_inc_len(rl));
                            m    = M_FRAC;
                            done = 1'b1;
                        end
                        else
                        begin
                            tok_new[n] = make_tok(KIND_NUMBER, ERR_NONE, ts, rl, ln, cl);
                            n  = n + 1'b1;
                            s  = ps;
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            tok_new[n] = make_tok(KIND_DOT, ERR_NONE, s,
                                                  LENGTH_BITS'(1), ln, cl);
                            n  = n + 1'b1;
                            m  = M_IDLE;
                        end
                    end
                    M_STRING:
                    begin
                        if (b == CH_NUL)
                        begin
                            tok_new[n] = make_tok(KIND_ERROR, ERR_UNTERMINATED, ts, rl,
                                                  ln, cl);
                            n  = n + 1'b1;
                            hl = 1'b1;
                        end
                        else
                        begin
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            rl = sat_inc_len(rl);
                            if (b == CH_QUOTE)
                            begin
                                tok_new[n] = make_tok(KIND_STRING, ERR_NONE, ts, rl, ln, cl);
                                n = n + 1'b1;
                                m = M_IDLE;
                            end
                            else if (b == CH_LF)
                            begin
                                ln = sat_inc_line(ln);
                                cl = LINE_BITS'(1);
                            end
                        end
                        done = 1'b1;
                    end
                    M_IDENT:
                    begin
                        if (is_sym(b))
                        begin
                            if (rl < LENGTH_BITS'(WORD_BYTES))
                            begin
                                wb = {wb[8*WORD_BYTES-9:0], b};
                            end
                            ps   = ps + 1'b1;
                            cl   = sat_inc_line(cl);
                            rl   = sat_inc_len(rl);
                            done = 1'b1;
                        end
                        else
                        begin
                            tok_new[n] = make_tok(kw_kind(wb, rl), ERR_NONE, ts, rl, ln, cl);
                            n = n + 1'b1;
                            m = M_IDLE;
                        end
                    end
                    M_OP:
                    begin
                        s = ps;
                        if (pair_match(hb, b))
                        begin
                            ps = ps + 2'd2;
                            cl = sat_inc_line(sat_inc_line(cl));
                            tok_new[n] = make_tok(pair_kind(hb), ERR_NONE, s,
                                                  LENGTH_BITS'(2), ln, cl);
                            n    = n + 1'b1;
                            m    = M_IDLE;
                            done = 1'b1;
                        end
                        else if (hb == CH_BANG)
                        begin
                            ts = ps;
                            wb = {{(8*WORD_BYTES-8){1'b0}}, hb};
                            rl = LENGTH_BITS'(1);
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            m  = M_IDENT;
                        end
                        else
                        begin
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            tok_new[n] = make_tok(punct_kind(hb), ERR_NONE, s,
                                                  LENGTH_BITS'(1), ln, cl);
                            n = n + 1'b1;
                            m = M_IDLE;
                        end
                    end
                    default:
                    begin
                        m = M_IDLE;
                        if (b == CH_NUL)
                        begin
                            tok_new[n] = make_tok(KIND_EOF, ERR_NONE, ps, '0, ln, cl);
                            n  = n + 1'b1;
                            hl = 1'b1;
                        end
                        else if ((b == CH_SPACE) || (b == CH_TAB))
                        begin
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                        end
                        else if (b == CH_SEMI)
                        begin
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            m  = M_COMMENT;
                        end
                        else if (is_digit(b) || (b == CH_QUOTE))
                        begin
                            ts = ps;
                            wb = '0;
                            rl = LENGTH_BITS'(1);
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            m  = is_digit(b) ? M_INT : M_STRING;
                        end
                        else if (is_op_start(b))
                        begin
                            hb = b;
                            m  = M_OP;
                        end
                        else if ((b == CH_LF) || (b == CH_CR))
                        begin
                            s  = ps;
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            tok_new[n] = make_tok(KIND_NEWLINE, ERR_NONE, s,
                                                  LENGTH_BITS'(1), ln, cl);
                            n  = n + 1'b1;
                            ln = sat_inc_line(ln);
                            cl = LINE_BITS'(1);
                        end
                        else if (punct_kind(b) != KIND_EOF)
                        begin
                            s  = ps;
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            tok_new[n] = make_tok(punct_kind(b), ERR_NONE, s,
                                                  LENGTH_BITS'(1), ln, cl);
                            n  = n + 1'b1;
                        end
                        else
                        begin
                            ts = ps;
                            wb = {{(8*WORD_BYTES-8){1'b0}}, b};
                            rl = LENGTH_BITS'(1);
                            ps = ps + 1'b1;
                            cl = sat_inc_line(cl);
                            m  = M_IDENT;
                        end
                        done = 1'b1;
                    end
                endcase
            end
        end

        if (n != '0)
        begin
            tok_new[n - 1'b1].last = 1'b1;
        end

        tok_count   = n;
        mode_next   = m;
        held_next   = hb;
        word_next   = wb;
        run_next    = rl;
        start_next  = ts;
        pos_next    = ps;
        line_next   = ln;
        col_next    = cl;
        halted_next = hl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            mode_reg       <= M_IDLE;
            held_reg       <= '0;
            word_reg       <= '0;
            run_reg        <= '0;
            start_reg      <= '0;
            pos_reg        <= '0;
            line_reg       <= LINE_BITS'(1);
            col_reg        <= LINE_BITS'(1);
            halted_reg     <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (fire)
            begin
                mode_reg   <= mode_next;
                held_reg   <= held_next;
                word_reg   <= word_next;
                run_reg    <= run_next;
                start_reg  <= start_next;
                pos_reg    <= pos_next;
                line_reg   <= line_next;
                col_reg    <= col_next;
                halted_reg <= halted_next;
            end
            wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(pop);
            count_reg  <= count_reg + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= text_byte;
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (RES_BITS'(i) < push_n)
            begin
                queue_reg[wr_ptr_reg + QPTR_BITS'(i)] <= tok_new[i];
            end
        end
    end

    assign out_valid     = (count_reg != '0);
    assign pop           = out_valid && out_ready;
    assign head          = queue_reg[rd_ptr_reg];
    assign token_kind    = head.kind;
    assign error_code    = head.err;
    assign start_offset  = head.start;
    assign token_length  = head.len;
    assign line_number   = head.line;
    assign column_number = head.col;
    assign last_of_run   = head.last;

endmodule
